@@ rtl/phb_pkg.sv @@
// Shared types, constants and checksum helper for the probe header builder.
package phb_pkg;

    // Header kinds as they arrive on the request channel.
    localparam logic [1:0] OP_TCP  = 2'd0;
    localparam logic [1:0] OP_UDP  = 2'd1;
    localparam logic [1:0] OP_IPV4 = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_IP_IDENT   = 1'b0;
    localparam logic CFG_TCP_WINDOW = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] IP_IDENT_RST   = 16'd54321;
    localparam logic [15:0] TCP_WINDOW_RST = 16'd2048;

    // Fixed header constants.
    localparam logic [15:0] PROTO_TCP   = 16'd6;
    localparam logic [15:0] PROTO_UDP   = 16'd17;
    localparam logic [15:0] TCP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [7:0]  TCP_OFFSET  = 8'h50;
    localparam logic [7:0]  IP_VER_IHL  = 8'h45;
    localparam logic [15:0] CSUM_ALL_ONES = 16'hffff;

    // Word count, checksum sum width and index of the last word per header kind.
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned SUM_W     = 20;
    localparam logic [2:0] LAST_TCP  = 3'd4;
    localparam logic [2:0] LAST_UDP  = 3'd1;
    localparam logic [2:0] LAST_IPV4 = 3'd4;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic [1:0]                      kind;
        logic [NUM_WORDS-1:0][31:0]      words;
        logic [SUM_W-1:0]                sum;
    } entry_t;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

    // Folds the carries of a one's complement sum and inverts it.
    function automatic logic [15:0] fold_invert(input logic [SUM_W-1:0] acc);
        logic [16:0] t;
        logic [16:0] u;
        t = {13'd0, acc[SUM_W-1:16]} + {1'b0, acc[15:0]};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        return ~u[15:0];
    endfunction

endpackage

@@ rtl/phb_if.sv @@
// Valid/ready channel interfaces for requests and header words.
interface probe_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [7:0]  tcp_flags;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [15:0] total_len;

    modport source (output valid, op, src_addr, dst_addr, src_port, dst_port, seq_num,
                    tcp_flags, ttl, protocol, total_len, input ready);
    modport sink   (input valid, op, src_addr, dst_addr, src_port, dst_port, seq_num,
                    tcp_flags, ttl, protocol, total_len, output ready);
endinterface

interface probe_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic        last;

    modport source (output valid, header_word, last, input ready);
    modport sink   (input valid, header_word, last, output ready);
endinterface

@@ rtl/probe_header_builder.sv @@
// Top level of the probe header builder: config registers, front end, queue, back end.
//
//  Channel | Dir | Handshake          | Contents
//  req     | in  | valid/ready        | op, addresses, ports, sequence, flags, ttl, ...
//  hdr     | out | valid/ready        | header_word, last
//  cfg     | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
// A TCP or IPv4 header takes five output transactions and a UDP header two; the
// one-word output channel sets the rate at which TCP and IPv4 headers go out.
// A request is taken whenever the queue has room, so requests keep flowing while
// earlier headers are still being sent. Reset clears the queue and output control
// and restores both configuration registers. A stalled output holds its word.
module probe_header_builder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    probe_req_if.sink   req,
    probe_hdr_if.source hdr,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import phb_pkg::*;

    logic [15:0] ip_ident_reg;
    logic [15:0] tcp_window_reg;
    logic        push;
    logic        pop;
    entry_t      push_data;
    entry_t      head;
    q_status_t   q_stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_ident_reg   <= IP_IDENT_RST;
            tcp_window_reg <= TCP_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IP_IDENT:   ip_ident_reg   <= cfg_data;
                CFG_TCP_WINDOW: tcp_window_reg <= cfg_data;
                default:        ip_ident_reg   <= ip_ident_reg;
            endcase
        end
    end

    phb_front u_front (
        .req        (req),
        .ip_ident   (ip_ident_reg),
        .tcp_window (tcp_window_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    phb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    phb_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .hdr    (hdr)
    );

    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("push into full queue");

    // The back end only takes an entry that is present.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.avail)
        else $error("pop from empty queue");

    // A word that is not the last one is always followed by another word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hdr.valid && hdr.ready && !hdr.last) |=> hdr.valid)
        else $error("header ended without last word");

endmodule

@@ rtl/phb_front.sv @@
// Front end: accepts requests, lays out header words and forms the raw checksum sum.
module phb_front (
    probe_req_if.sink            req,
    input  logic [15:0]          ip_ident,
    input  logic [15:0]          tcp_window,
    input  phb_pkg::q_status_t   q_stat,
    output logic                 push,
    output phb_pkg::entry_t      push_data
);
    import phb_pkg::*;

    logic [SUM_W-1:0] addr_sum;
    logic [SUM_W-1:0] port_sum;
    logic [15:0]      tcp_ctl;

    // Requests are taken whenever the queue has room; unused kinds are dropped.
    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full && (req.op != OP_NONE);

    // Sums shared by the pseudo-header checksums.
    assign addr_sum = SUM_W'(req.src_addr[31:16]) + SUM_W'(req.src_addr[15:0])
                    + SUM_W'(req.dst_addr[31:16]) + SUM_W'(req.dst_addr[15:0]);
    assign port_sum = SUM_W'(req.src_port) + SUM_W'(req.dst_port);
    assign tcp_ctl  = {TCP_OFFSET, req.tcp_flags};

    // Word layout per header kind; checksum slots stay zero until the back end fills them.
    always_comb
    begin
        push_data       = '0;
        push_data.kind  = req.op;
        unique case (req.op)
            OP_TCP:
            begin
                push_data.words[0] = {req.src_port, req.dst_port};
                push_data.words[1] = req.seq_num;
                push_data.words[2] = 32'd0;
                push_data.words[3] = {tcp_ctl, tcp_window};
                push_data.words[4] = 32'd0;
                push_data.sum = addr_sum + port_sum + SUM_W'(PROTO_TCP) + SUM_W'(TCP_HDR_LEN)
                              + SUM_W'(req.seq_num[31:16]) + SUM_W'(req.seq_num[15:0])
                              + SUM_W'(tcp_ctl) + SUM_W'(tcp_window);
            end
            OP_UDP:
            begin
                push_data.words[0] = {req.src_port, req.dst_port};
                push_data.words[1] = {UDP_HDR_LEN, 16'd0};
                push_data.sum = addr_sum + port_sum + SUM_W'(PROTO_UDP)
                              + SUM_W'(UDP_HDR_LEN) + SUM_W'(UDP_HDR_LEN);
            end
            OP_IPV4:
            begin
                push_data.words[0] = {IP_VER_IHL, 8'd0, req.total_len};
                push_data.words[1] = {ip_ident, 16'd0};
                push_data.words[2] = {req.ttl, req.protocol, 16'd0};
                push_data.words[3] = req.src_addr;
                push_data.words[4] = req.dst_addr;
                push_data.sum = addr_sum + SUM_W'({IP_VER_IHL, 8'd0}) + SUM_W'(req.total_len)
                              + SUM_W'(ip_ident) + SUM_W'({req.ttl, req.protocol});
            end
            default:
            begin
                push_data.sum = '0;
            end
        endcase
    end

endmodule

@@ rtl/phb_queue.sv @@
// Short queue of classified requests between the front and back ends.
module phb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  phb_pkg::entry_t     push_data,
    input  logic                pop,
    output phb_pkg::entry_t     head,
    output phb_pkg::q_status_t  q_stat
);
    import phb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Storage; entries need no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.avail = (count_reg != '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/phb_back.sv @@
// Back end: finishes the checksum and sends the header one word per transaction.
module phb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  phb_pkg::entry_t     head,
    input  phb_pkg::q_status_t  q_stat,
    output logic                pop,
    probe_hdr_if.source         hdr
);
    import phb_pkg::*;

    logic                       cur_valid_reg, cur_valid_next;
    logic [NUM_WORDS-1:0][31:0] cur_words_reg, cur_words_next;
    logic [2:0]                 idx_reg, idx_next;
    logic [2:0]                 last_idx_reg, last_idx_next;
    logic [15:0]                csum;
    logic [NUM_WORDS-1:0][31:0] ins_words;
    logic [2:0]                 ins_last;
    logic                       is_last;
    logic                       word_done;

    // Checksum insertion into the head entry.
    always_comb
    begin
        csum      = fold_invert(head.sum);
        ins_words = head.words;
        ins_last  = LAST_TCP;
        unique case (head.kind)
            OP_TCP:
            begin
                ins_words[4][31:16] = csum;
                ins_last = LAST_TCP;
            end
            OP_UDP:
            begin
                ins_words[1][15:0] = (csum == 16'd0) ? CSUM_ALL_ONES : csum;
                ins_last = LAST_UDP;
            end
            OP_IPV4:
            begin
                ins_words[2][15:0] = csum;
                ins_last = LAST_IPV4;
            end
            default:
            begin
                ins_last = LAST_TCP;
            end
        endcase
    end

    // Output channel driven from the current header registers.
    assign is_last         = (idx_reg == last_idx_reg);
    assign hdr.valid       = cur_valid_reg;
    assign hdr.header_word = cur_words_reg[idx_reg[2:0]];
    assign hdr.last        = is_last;
    assign word_done       = cur_valid_reg && hdr.ready;

    // Load the next header when idle or as the final word of the current one leaves.
    assign pop = q_stat.avail && (!cur_valid_reg || (word_done && is_last));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_words_next = cur_words_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_words_next = ins_words;
            idx_next       = '0;
            last_idx_next  = ins_last;
        end
        else if (word_done)
        begin
            if (is_last)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_words_reg <= cur_words_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
        end
    end

endmodule

@@ sim/probe_header_builder_test.sv @@
// Self-checking testbench for the probe header builder: TCP, UDP and IPv4 header words.
module probe_header_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import phb_pkg::*;

    // Cycles allowed for a dropped request to leave the block before a register write.
    localparam int SETTLE_CYCLES = 20;
    // Bound on the wait for outstanding header words at a phase boundary.
    localparam int DRAIN_LIMIT = 5000;

    // One request as offered on the input channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [7:0]  tcp_flags;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [15:0] total_len;
    } probe_req_t;

    // One header word as it should leave the block.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } hdr_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    probe_req_if req_ch ();
    probe_hdr_if hdr_ch ();

    probe_header_builder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .hdr       (hdr_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copies of the configuration registers.
    logic [15:0] ident_reg;
    logic [15:0] window_reg;

    // Header words predicted but not yet seen on the output.
    hdr_word_t pending_words[$];
    hdr_word_t next_word;

    // Idling controls shared by the sender, the receiver and the tests.
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_request;

    // Run statistics.
    int error_count;
    int words_checked;
    int tcp_sent;
    int udp_sent;
    int ipv4_sent;
    int none_sent;
    int cfg_writes;

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d header words still outstanding.", pending_words.size());
        $display("status: fail");
        $finish;
    end

    // Adds both 16-bit halves of a word into a one's complement accumulator.
    function automatic logic [31:0] add_halves(input logic [31:0] acc, input logic [31:0] w);
        return acc + w[31:16] + w[15:0];
    endfunction

    // Folds the carries back in until 16 bits remain, then complements.
    function automatic logic [15:0] fold_complement(input logic [31:0] acc);
        while (acc[31:16] != 16'd0)
            acc = acc[31:16] + acc[15:0];
        return ~acc[15:0];
    endfunction

    // Computes the header words for one accepted request and queues them.
    task automatic predict_header(input probe_req_t r);
        logic [31:0] w [5];
        logic [31:0] acc;
        logic [15:0] csum;
        int          n;
        n = 0;
        case (r.op)
            OP_TCP:
            begin
                w[0] = {r.src_port, r.dst_port};
                w[1] = r.seq_num;
                w[2] = 32'd0;
                w[3] = {TCP_OFFSET, r.tcp_flags, window_reg};
                w[4] = 32'd0;
                acc = add_halves(add_halves(32'd0, r.src_addr), r.dst_addr);
                acc = acc + PROTO_TCP + TCP_HDR_LEN;
                for (int i = 0; i < 5; i++)
                    acc = add_halves(acc, w[i]);
                csum = fold_complement(acc);
                w[4] = {csum, 16'd0};
                n = 5;
            end
            OP_UDP:
            begin
                w[0] = {r.src_port, r.dst_port};
                w[1] = {UDP_HDR_LEN, 16'd0};
                acc = add_halves(add_halves(32'd0, r.src_addr), r.dst_addr);
                acc = acc + PROTO_UDP + UDP_HDR_LEN;
                acc = add_halves(add_halves(acc, w[0]), w[1]);
                csum = fold_complement(acc);
                // A zero checksum means "none" in UDP, so it goes out as all ones.
                if (csum == 16'd0)
                    csum = CSUM_ALL_ONES;
                w[1][15:0] = csum;
                n = 2;
            end
            OP_IPV4:
            begin
                w[0] = {IP_VER_IHL, 8'd0, r.total_len};
                w[1] = {ident_reg, 16'd0};
                w[2] = {r.ttl, r.protocol, 16'd0};
                w[3] = r.src_addr;
                w[4] = r.dst_addr;
                acc = 32'd0;
                for (int i = 0; i < 5; i++)
                    acc = add_halves(acc, w[i]);
                w[2][15:0] = fold_complement(acc);
                n = 5;
            end
            default:
                n = 0;
        endcase
        for (int k = 0; k < n; k++)
            pending_words.push_back('{word: w[k], last: (k == n - 1)});
    endtask

    // Records one failure; only the first few are printed.
    task automatic report_error(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
    endtask

    // Compares each output transaction with the oldest predicted word.
    always @(posedge clk)
    begin
        if (rst_n && hdr_ch.valid && hdr_ch.ready)
        begin
            words_checked++;
            if (pending_words.size() == 0)
                report_error("unexpected header word", 32'd0, hdr_ch.header_word);
            else
            begin
                next_word = pending_words.pop_front();
                if (hdr_ch.header_word !== next_word.word)
                    report_error("header_word", next_word.word, hdr_ch.header_word);
                if (hdr_ch.last !== next_word.last)
                    report_error("last", {31'd0, next_word.last}, {31'd0, hdr_ch.last});
            end
        end
    end

    // Output side: random stall bursts, plus a long counted hold when a test asks.
    initial
    begin
        int held;
        hdr_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hdr_ch.ready <= 1'b0;
                held = 0;
                while (held < hold_request)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_request = 0;
                hdr_ch.ready <= 1'b1;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct / 4)
            begin
                hdr_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                hdr_ch.ready <= 1'b1;
            end
            else
                hdr_ch.ready <= 1'b1;
        end
    end

    // Writes one configuration register and updates its shadow copy.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_IP_IDENT)
            ident_reg = value;
        else
            window_reg = value;
        cfg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one request, waits for the transaction and predicts its header.
    task automatic send_request(input probe_req_t r);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_ch.op        <= r.op;
        req_ch.src_addr  <= r.src_addr;
        req_ch.dst_addr  <= r.dst_addr;
        req_ch.src_port  <= r.src_port;
        req_ch.dst_port  <= r.dst_port;
        req_ch.seq_num   <= r.seq_num;
        req_ch.tcp_flags <= r.tcp_flags;
        req_ch.ttl       <= r.ttl;
        req_ch.protocol  <= r.protocol;
        req_ch.total_len <= r.total_len;
        req_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_header(r);
        case (r.op)
            OP_TCP:  tcp_sent++;
            OP_UDP:  udp_sent++;
            OP_IPV4: ipv4_sent++;
            default: none_sent++;
        endcase
    endtask

    // Stops offering, waits for every predicted word, then lets the block settle.
    task automatic wait_until_idle();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_words.size() != 0)
        begin
            error_count += pending_words.size();
            $display("ERROR at %0t: %0d header words never arrived",
                     $realtime, pending_words.size());
            pending_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly random values, with zero and all ones mixed in.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 36)
            return OP_TCP;
        else if (r < 68)
            return OP_UDP;
        else if (r < 96)
            return OP_IPV4;
        return OP_NONE;
    endfunction

    function automatic probe_req_t random_request(input logic [1:0] op);
        probe_req_t r;
        logic [31:0] v;
        r.op        = op;
        r.src_addr  = pick_value();
        r.dst_addr  = pick_value();
        v = pick_value();
        r.src_port  = v[15:0];
        v = pick_value();
        r.dst_port  = v[15:0];
        r.seq_num   = pick_value();
        v = pick_value();
        r.tcp_flags = v[7:0];
        v = pick_value();
        r.ttl       = v[7:0];
        v = pick_value();
        r.protocol  = v[7:0];
        v = pick_value();
        r.total_len = v[15:0];
        return r;
    endfunction

    function automatic probe_req_t make_request(
        input logic [1:0] op, input logic [31:0] src, input logic [31:0] dst,
        input logic [15:0] sport, input logic [15:0] dport, input logic [31:0] seq,
        input logic [7:0] flags, input logic [7:0] ttl, input logic [7:0] proto,
        input logic [15:0] tlen);
        return '{op: op, src_addr: src, dst_addr: dst, src_port: sport, dst_port: dport,
                 seq_num: seq, tcp_flags: flags, ttl: ttl, protocol: proto,
                 total_len: tlen};
    endfunction

    // Field extremes, every header kind, the unused op and the zero UDP checksum.
    task automatic test_directed_headers();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_request(make_request(OP_TCP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_TCP, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_request(OP_UDP, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_UDP, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        // Pseudo-header sum lands on 0xffff, so the computed checksum is zero.
        send_request(make_request(OP_UDP, 0, 0, 16'h0000, 16'hffde, 0, 0, 0, 0, 0));
        send_request(make_request(OP_IPV4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_IPV4, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_request(OP_IPV4, 32'hc0a80001, 32'h0a000001, 0, 0, 0, 0,
                                  8'd64, 8'd6, 16'd40));
        send_request(make_request(OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1));
        send_request(make_request(OP_TCP, 32'hc0a80001, 32'h08080808, 16'd40000, 16'd80,
                                  32'h12345678, 8'h02, 8'h5a, 8'ha5, 16'h1234));
        send_request(make_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_request(OP_UDP, 32'h7f000001, 32'h7f000001, 16'd53, 16'd53,
                                  32'hdeadbeef, 8'hff, 8'h11, 8'h22, 16'h3344));
        wait_until_idle();
    endtask

    // Both registers at their extremes and at random values.
    task automatic test_register_settings();
        logic [31:0] v;
        for (int s = 0; s < 4; s++)
        begin
            if (s == 0)
            begin
                write_reg(CFG_IP_IDENT, 16'h0000);
                write_reg(CFG_TCP_WINDOW, 16'h0000);
            end
            else if (s == 1)
            begin
                write_reg(CFG_IP_IDENT, 16'hffff);
                write_reg(CFG_TCP_WINDOW, 16'hffff);
            end
            else
            begin
                v = $urandom;
                write_reg(CFG_IP_IDENT, v[15:0]);
                write_reg(CFG_TCP_WINDOW, v[31:16]);
            end
            send_request(random_request(OP_TCP));
            send_request(random_request(OP_IPV4));
            send_request(random_request(OP_UDP));
            wait_until_idle();
        end
    endtask

    // Output held off for a long stretch while requests keep coming back to back.
    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 300;
        for (int i = 0; i < 12; i++)
            send_request(random_request(pick_op()));
        wait_until_idle();
    endtask

    // Random requests in phases; registers and idling change between phases.
    task automatic test_random_traffic();
        probe_req_t  r;
        logic [31:0] v;
        int          sent;
        for (int phase = 0; phase < 6; phase++)
        begin
            v = pick_value();
            write_reg(CFG_IP_IDENT, v[15:0]);
            v = pick_value();
            write_reg(CFG_TCP_WINDOW, v[15:0]);
            tx_idle_pct = $urandom_range(0, 3) * 20;
            rx_idle_pct = $urandom_range(0, 3) * 20;
            sent = 0;
            while (sent < 34)
            begin
                r = random_request(pick_op());
                send_request(r);
                if (r.op != OP_NONE)
                    sent++;
            end
            wait_until_idle();
        end
    endtask

    // Last stretch at full rate on both sides.
    task automatic test_full_rate_tail();
        probe_req_t r;
        int         sent;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        sent = 0;
        while (sent < 30)
        begin
            r = random_request(pick_op());
            send_request(r);
            if (r.op != OP_NONE)
                sent++;
        end
        wait_until_idle();
    endtask

    // Reset, run every test in turn, then report.
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_IP_IDENT;
        cfg_data         = 16'd0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_NONE;
        req_ch.src_addr  = 32'd0;
        req_ch.dst_addr  = 32'd0;
        req_ch.src_port  = 16'd0;
        req_ch.dst_port  = 16'd0;
        req_ch.seq_num   = 32'd0;
        req_ch.tcp_flags = 8'd0;
        req_ch.ttl       = 8'd0;
        req_ch.protocol  = 8'd0;
        req_ch.total_len = 16'd0;
        ident_reg        = IP_IDENT_RST;
        window_reg       = TCP_WINDOW_RST;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        hold_request     = 0;
        error_count      = 0;
        words_checked    = 0;
        tcp_sent         = 0;
        udp_sent         = 0;
        ipv4_sent        = 0;
        none_sent        = 0;
        cfg_writes       = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_headers();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        test_full_rate_tail();

        $display("Run covered %0d TCP, %0d UDP, %0d IPv4 and %0d unused-op requests.",
                 tcp_sent, udp_sent, ipv4_sent, none_sent);
        $display("%0d header words checked across %0d register writes, %0d errors.",
                 words_checked, cfg_writes, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ probe_header_builder.f @@
rtl/phb_pkg.sv
rtl/phb_if.sv
rtl/phb_front.sv
rtl/phb_queue.sv
rtl/phb_back.sv
rtl/probe_header_builder.sv
sim/probe_header_builder_test.sv
